// ----- src/aemg_pkg.sv -----
// ----------------------------------------------------------------------------
// aemg_pkg
// Shared widths, register codes and pipeline payload types of the Abel matrix
// entry generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aemg_pkg;

  localparam int STEP_W  = 32;
  localparam int SIZE_W  = 9;
  localparam int COORD_W = 8;
  localparam int IDX_W   = 24;
  localparam int LEN_W   = 41;
  localparam int ROOT_W  = 41;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int CFG_AW  = 3;

  typedef enum logic [CFG_AW-1:0] {
    REG_HALF_SIDE = 3'd0,
    REG_BIN_COUNT = 3'd1,
    REG_ROW_STEP  = 3'd2,
    REG_COL_STEP  = 3'd3,
    REG_BIN_STEP  = 3'd4
  } cfg_reg_t;

  // carried along the radius root chain
  typedef struct packed {
    logic [RAD_W-1:0]  s2;
    logic [RAD_W-1:0]  osq;
    logic [RAD_W-1:0]  ksq;
    logic [ROOT_W-1:0] outer;
    logic [ROOT_W-2:0] kstep;
    logic              knz;
    logic [IDX_W-1:0]  idx;
  } s_pay_t;

  // carried along the leg root chains
  typedef struct packed {
    logic             written;
    logic [IDX_W-1:0] idx;
  } l_pay_t;

endpackage

// ----- src/aemg_in_if.sv -----
// ----------------------------------------------------------------------------
// aemg_in_if
// Input channel: one matrix entry request per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface aemg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_row;
  logic [7:0] pixel_col;
  logic [7:0] radial_bin;

  modport source (output valid, pixel_row, pixel_col, radial_bin, input ready);
  modport sink   (input valid, pixel_row, pixel_col, radial_bin, output ready);
endinterface

// ----- src/aemg_out_if.sv -----
// ----------------------------------------------------------------------------
// aemg_out_if
// Result channel: one matrix entry per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface aemg_out_if;
  logic        valid;
  logic        ready;
  logic        written;
  logic [23:0] flat_index;
  logic [40:0] path_length;

  modport source (output valid, written, flat_index, path_length, input ready);
  modport sink   (input valid, written, flat_index, path_length, output ready);
endinterface

// ----- src/aemg_cfg_if.sv -----
// ----------------------------------------------------------------------------
// aemg_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface aemg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/aemg_square.sv -----
// ----------------------------------------------------------------------------
// aemg_square
// Two-stage squarer for a 41-bit value: split partial products, then sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aemg_square
  import aemg_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [ROOT_W-1:0] a,
  output logic [RAD_W-1:0]  sq
);

  localparam int LO_W = (ROOT_W + 1) / 2;
  localparam int HI_W = ROOT_W - LO_W;

  logic [2*LO_W-1:0]      p_ll_r;
  logic [HI_W+LO_W-1:0]   p_hl_r;
  logic [2*HI_W-1:0]      p_hh_r;
  logic [RAD_W-1:0]       sq_r;

  // stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p_ll_r <= a[LO_W-1:0] * a[LO_W-1:0];
      p_hl_r <= a[ROOT_W-1:LO_W] * a[LO_W-1:0];
      p_hh_r <= a[ROOT_W-1:LO_W] * a[ROOT_W-1:LO_W];
    end
  end

  // stage 2: weighted sum, cross term doubled
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= (RAD_W'(p_hh_r) << (2 * LO_W)) + (RAD_W'(p_hl_r) << (LO_W + 1))
            + RAD_W'(p_ll_r);
    end
  end

  assign sq = sq_r;

endmodule

// ----- src/aemg_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// aemg_sqrt_cell
// One digit step of a restoring integer square root, with a side payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aemg_sqrt_cell
  import aemg_pkg::*;
#(
  parameter int PW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [REM_W-1:0]  rem_i,
  input  logic [PW-1:0]     pay_i,
  output logic              v_o,
  output logic [RAD_W-1:0]  rad_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [REM_W-1:0]  rem_o,
  output logic [PW-1:0]     pay_o
);

  logic              v_r;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W-1:0]  rem_r;
  logic [PW-1:0]     pay_r;

  logic [REM_W+1:0]  cur;
  logic [REM_W+1:0]  trial;
  logic              ge;
  logic [REM_W+1:0]  diff;

  // bring down two radicand bits, try root digit 1
  always_comb begin
    cur   = {rem_i, rad_i[RAD_W-1 -: 2]};
    trial = (REM_W+2)'({root_i, 2'b01});
    ge    = cur >= trial;
    diff  = cur - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_i << 2;
      root_r <= {root_i[ROOT_W-2:0], ge};
      rem_r  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
      pay_r  <= pay_i;
    end
  end

  assign v_o    = v_r;
  assign rad_o  = rad_r;
  assign root_o = root_r;
  assign rem_o  = rem_r;
  assign pay_o  = pay_r;

endmodule

// ----- src/aemg_sqrt_chain.sv -----
// ----------------------------------------------------------------------------
// aemg_sqrt_chain
// Row of square root cells, one root bit per cell, one item per cycle while en is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aemg_sqrt_chain
  import aemg_pkg::*;
#(
  parameter int PW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [PW-1:0]     pay_i,
  output logic              v_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [REM_W-1:0]  rem_o,
  output logic [PW-1:0]     pay_o
);

  logic              v   [ROOT_W+1];
  logic [RAD_W-1:0]  rad [ROOT_W+1];
  logic [ROOT_W-1:0] root[ROOT_W+1];
  logic [REM_W-1:0]  rem [ROOT_W+1];
  logic [PW-1:0]     pay [ROOT_W+1];

  assign v[0]    = v_i;
  assign rad[0]  = rad_i;
  assign root[0] = '0;
  assign rem[0]  = '0;
  assign pay[0]  = pay_i;

  for (genvar c = 0; c < ROOT_W; c++) begin : g_cell
    aemg_sqrt_cell #(.PW(PW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (v[c]),
      .rad_i  (rad[c]),
      .root_i (root[c]),
      .rem_i  (rem[c]),
      .pay_i  (pay[c]),
      .v_o    (v[c+1]),
      .rad_o  (rad[c+1]),
      .root_o (root[c+1]),
      .rem_o  (rem[c+1]),
      .pay_o  (pay[c+1])
    );
  end

  assign v_o    = v[ROOT_W];
  assign root_o = root[ROOT_W];
  assign rem_o  = rem[ROOT_W];
  assign pay_o  = pay[ROOT_W];

endmodule

// ----- src/abel_matrix_entry_generator.sv -----
// Item path: stages 0-3, radius root chain, post 1-2, leg root chains, output.
// Throughput: one item per cycle, set by the 41-cell root chains that each hold
// one item per cell; the output register holds one finished result.
// Stalls only when the last chain cell holds an item and the result waits.
// Reset (rst_n, synchronous): all valid bits cleared, registers back to their
// defaults (half side 128, bins 128, all steps 1.0).
// ----------------------------------------------------------------------------
// abel_matrix_entry_generator
// Abel transform matrix entries: radius root, then two leg roots, in a
// pipeline of square root cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abel_matrix_entry_generator
  import aemg_pkg::*;
#(
  parameter int MAX_HALF_SIDE = 256,
  parameter int MAX_BINS      = 256,
  parameter int FRAC_BITS     = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  aemg_in_if.sink    in_ch,
  aemg_out_if.source out_ch,
  aemg_cfg_if.sink   cfg_ch
);

  localparam logic [STEP_W-1:0] ONE = STEP_W'(64'd1 << FRAC_BITS);

  // configuration registers
  logic [SIZE_W-1:0] half_r, bins_r;
  logic [STEP_W-1:0] row_step_r, col_step_r, bin_step_r;
  logic [SIZE_W-1:0] cfg_size;

  assign cfg_ch.ready = 1'b1;
  assign cfg_size     = cfg_ch.data[SIZE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r     <= SIZE_W'(128);
      bins_r     <= SIZE_W'(128);
      row_step_r <= ONE;
      col_step_r <= ONE;
      bin_step_r <= ONE;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_HALF_SIDE: half_r <= (32'(cfg_size) > 32'(MAX_HALF_SIDE)) ?
                                 SIZE_W'(MAX_HALF_SIDE) : cfg_size;
        REG_BIN_COUNT: bins_r <= (32'(cfg_size) > 32'(MAX_BINS)) ?
                                 SIZE_W'(MAX_BINS) : cfg_size;
        REG_ROW_STEP:  row_step_r <= cfg_ch.data;
        REG_COL_STEP:  col_step_r <= cfg_ch.data;
        REG_BIN_STEP:  bin_step_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // pipeline enable: hold only when the last cell and the output are both full and the output is not taken
  logic   en;
  logic   c2_v;
  logic   out_valid_r;

  assign en          = !out_valid_r || out_ch.ready || !c2_v;
  assign in_ch.ready = en;

  // stage 0: coordinates, bin edges, index terms
  logic              v0_r;
  logic [ROOT_W-2:0] z0_r, y0_r, kstep0_r;
  logic [ROOT_W-1:0] outer0_r;
  logic              knz0_r;
  logic [IDX_W-1:0]  t1_r, t2_r, kb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z0_r     <= in_ch.pixel_row * row_step_r;
      y0_r     <= in_ch.pixel_col * col_step_r;
      outer0_r <= ({1'b0, in_ch.radial_bin} + 9'd1) * bin_step_r;
      kstep0_r <= in_ch.radial_bin * bin_step_r;
      knz0_r   <= in_ch.radial_bin != '0;
      t1_r     <= IDX_W'((IDX_W'(half_r) - IDX_W'(1) - IDX_W'(in_ch.pixel_row))
                         * IDX_W'(half_r));
      t2_r     <= IDX_W'((IDX_W'(half_r) - IDX_W'(1) - IDX_W'(in_ch.pixel_col))
                         * IDX_W'(bins_r));
      kb_r     <= IDX_W'(bins_r) - IDX_W'(1) - IDX_W'(in_ch.radial_bin);
    end
  end

  // stages 1-2: squares
  logic [RAD_W-1:0] ysq, zsq, osq, ksq;

  aemg_square u_sq_y (.clk(clk), .en(en), .a({1'b0, y0_r}),     .sq(ysq));
  aemg_square u_sq_z (.clk(clk), .en(en), .a({1'b0, z0_r}),     .sq(zsq));
  aemg_square u_sq_o (.clk(clk), .en(en), .a(outer0_r),         .sq(osq));
  aemg_square u_sq_k (.clk(clk), .en(en), .a({1'b0, kstep0_r}), .sq(ksq));

  logic              v1_r, v2_r, v3_r;
  logic [ROOT_W-1:0] outer1_r, outer2_r;
  logic [ROOT_W-2:0] kstep1_r, kstep2_r;
  logic              knz1_r, knz2_r;
  logic [IDX_W-1:0]  idx1_r, idx2_r;
  s_pay_t            s_pay3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      outer1_r <= outer0_r;
      kstep1_r <= kstep0_r;
      knz1_r   <= knz0_r;
      idx1_r   <= IDX_W'(t1_r * IDX_W'(bins_r)) + t2_r + kb_r;
      outer2_r <= outer1_r;
      kstep2_r <= kstep1_r;
      knz2_r   <= knz1_r;
      idx2_r   <= idx1_r;
      // stage 3: radius squared
      s_pay3_r.s2    <= ysq + zsq;
      s_pay3_r.osq   <= osq;
      s_pay3_r.ksq   <= ksq;
      s_pay3_r.outer <= outer2_r;
      s_pay3_r.kstep <= kstep2_r;
      s_pay3_r.knz   <= knz2_r;
      s_pay3_r.idx   <= idx2_r;
    end
  end

  // radius root chain
  logic              c1_v;
  logic [ROOT_W-1:0] s_root;
  logic [REM_W-1:0]  s_rem;
  s_pay_t            s_pay;

  aemg_sqrt_chain #(.PW($bits(s_pay_t))) u_root_s (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(v3_r), .rad_i(s_pay3_r.s2),
    .pay_i(s_pay3_r), .v_o(c1_v), .root_o(s_root), .rem_o(s_rem), .pay_o(s_pay)
  );

  // post 1: s squared from the remainder, written flag, inner edge choice
  logic             p1_v_r, p1_wr_r, p1_isel_r;
  logic [RAD_W-1:0] p1_ssq_r, p1_osq_r, p1_ksq_r;
  logic [IDX_W-1:0] p1_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p1_v_r <= 1'b0;
    else if (en) p1_v_r <= c1_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_ssq_r  <= s_pay.s2 - RAD_W'(s_rem);
      p1_osq_r  <= s_pay.osq;
      p1_ksq_r  <= s_pay.ksq;
      p1_wr_r   <= s_pay.outer > s_root;
      p1_isel_r <= s_pay.knz && ({1'b0, s_pay.kstep} >= s_root);
      p1_idx_r  <= s_pay.idx;
    end
  end

  // post 2: leg radicands
  logic             p2_v_r;
  logic [RAD_W-1:0] d_out_r, d_in_r;
  l_pay_t           l_pay2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p2_v_r <= 1'b0;
    else if (en) p2_v_r <= p1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out_r          <= p1_wr_r ? p1_osq_r - p1_ssq_r : '0;
      d_in_r           <= (p1_wr_r && p1_isel_r) ? p1_ksq_r - p1_ssq_r : '0;
      l_pay2_r.written <= p1_wr_r;
      l_pay2_r.idx     <= p1_idx_r;
    end
  end

  // leg root chains
  logic [ROOT_W-1:0] leg_o, leg_i;
  l_pay_t            l_pay;

  aemg_sqrt_chain #(.PW($bits(l_pay_t))) u_root_o (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(p2_v_r), .rad_i(d_out_r),
    .pay_i(l_pay2_r), .v_o(c2_v), .root_o(leg_o), .rem_o(), .pay_o(l_pay)
  );

  aemg_sqrt_chain #(.PW(1)) u_root_i (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(p2_v_r), .rad_i(d_in_r),
    .pay_i(1'b0), .v_o(), .root_o(leg_i), .rem_o(), .pay_o()
  );

  // output register
  logic             out_wr_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [LEN_W-1:0] out_len_r;
  logic [ROOT_W:0]  len_diff;

  assign len_diff = {1'b0, leg_o} - {1'b0, leg_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_wr_r  <= l_pay.written;
      out_idx_r <= l_pay.written ? l_pay.idx : '0;
      out_len_r <= l_pay.written ? {len_diff[LEN_W-2:0], 1'b0} : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.written     = out_wr_r;
  assign out_ch.flat_index  = out_idx_r;
  assign out_ch.path_length = out_len_r;

`ifndef SYNTHESIS
  a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_wr_r |-> out_idx_r == '0 && out_len_r == '0)
    else $error("unwritten entry carries a non-zero result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !en |-> out_valid_r && !out_ch.ready && c2_v)
    else $error("input held off without a waiting result");

  a_leg_masked: assert property (@(posedge clk) disable iff (!rst_n)
    en && p1_v_r && !p1_wr_r |=> d_out_r == '0 && d_in_r == '0)
    else $error("leg radicand not cleared for an unwritten entry");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid_r && !c2_v)
    else $error("pipeline not empty after reset");
`endif

endmodule
